### design/unpm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the RGBA16 premultiplied to RGBA8 straight converter.
// No dependencies.
package unpm_pkg;

	localparam int CH_W       = 16;
	localparam int OUT_W      = 8;
	localparam int PROD_W     = 2 * CH_W;
	localparam int DIV_STEPS  = OUT_W + 1;
	localparam int QUO_W      = DIV_STEPS;
	localparam int PIPE_DEPTH = DIV_STEPS + 1;
	localparam int FIFO_DEPTH = 2;
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	localparam logic [OUT_W-1:0] CH_MAX = {OUT_W{1'b1}};

	typedef logic [CH_W-1:0]  chan_t;
	typedef logic [OUT_W-1:0] byte_t;

	typedef struct packed {
		byte_t red;
		byte_t green;
		byte_t blue;
		byte_t alpha;
	} pixel_t;

endpackage

### design/unpm_lane.sv
`timescale 1ns / 1ps
// One color lane: c * 65535 followed by a pipelined restoring divider, one quotient bit
// per stage, then saturation and the zero-alpha override. Depends on unpm_pkg.
module unpm_lane (
	input  logic          clk,
	input  logic          en,
	input  unpm_pkg::chan_t color,
	input  unpm_pkg::chan_t alpha,
	output unpm_pkg::byte_t straight
);
	import unpm_pkg::*;

	logic [PROD_W-1:0] rem_s   [DIV_STEPS];
	chan_t             alpha_s [DIV_STEPS];
	logic [QUO_W-1:0]  quo_s   [1:DIV_STEPS];
	logic              zero_s  [PIPE_DEPTH];

	// color * 65535 = (color << 16) - color
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]   <= {color, {CH_W{1'b0}}} - {{CH_W{1'b0}}, color};
			alpha_s[0] <= alpha;
			zero_s[0]  <= (alpha == '0);
		end
	end

	genvar j;
	generate
		for (j = 1; j <= DIV_STEPS; j++) begin : g_step
			localparam int SH = OUT_W + DIV_STEPS - j;
			logic [PROD_W-1:0] trial;
			logic              ge;

			assign trial = {{(PROD_W-CH_W){1'b0}}, alpha_s[j-1]} << SH;
			assign ge    = (rem_s[j-1] >= trial);

			always_ff @(posedge clk) begin
				if (en) begin
					zero_s[j] <= zero_s[j-1];
				end
			end

			if (j == 1) begin : g_first
				always_ff @(posedge clk) begin
					if (en) begin
						quo_s[j] <= {{(QUO_W-1){1'b0}}, ge};
					end
				end
			end else begin : g_next
				always_ff @(posedge clk) begin
					if (en) begin
						quo_s[j] <= {quo_s[j-1][QUO_W-2:0], ge};
					end
				end
			end

			if (j < DIV_STEPS) begin : g_rem
				always_ff @(posedge clk) begin
					if (en) begin
						rem_s[j]   <= ge ? (rem_s[j-1] - trial) : rem_s[j-1];
						alpha_s[j] <= alpha_s[j-1];
					end
				end
			end
		end
	endgenerate

	always_comb begin
		if (zero_s[DIV_STEPS]) begin
			straight = '0;
		end else if (quo_s[DIV_STEPS][QUO_W-1]) begin
			straight = CH_MAX;
		end else begin
			straight = quo_s[DIV_STEPS][OUT_W-1:0];
		end
	end

endmodule

### design/unpm_merge.sv
`timescale 1ns / 1ps
// Merge stage: gathers the lane results and alpha into one pixel and holds it in a
// two-entry output queue that decouples the output handshake. Depends on unpm_pkg.
module unpm_merge (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  unpm_pkg::byte_t  red,
	input  unpm_pkg::byte_t  green,
	input  unpm_pkg::byte_t  blue,
	input  unpm_pkg::byte_t  alpha,
	output logic             room,
	output logic             valid,
	input  logic             ready,
	output unpm_pkg::pixel_t pix
);
	import unpm_pkg::*;

	pixel_t           head_q;
	pixel_t           tail_q;
	pixel_t           new_pix;
	logic [CNT_W-1:0] cnt_q;
	logic             pop;

	assign new_pix = '{red: red, green: green, blue: blue, alpha: alpha};
	assign valid   = (cnt_q != '0);
	assign room    = (cnt_q != CNT_W'(FIFO_DEPTH));
	assign pop     = valid && ready;
	assign pix     = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		priority if (pop && push) begin
			if (cnt_q == CNT_W'(1)) begin
				head_q <= new_pix;
			end else begin
				head_q <= tail_q;
				tail_q <= new_pix;
			end
		end else if (pop) begin
			head_q <= tail_q;
		end else if (push) begin
			if (cnt_q == '0) begin
				head_q <= new_pix;
			end else begin
				tail_q <= new_pix;
			end
		end
	end

endmodule

### design/rgba16_premult_to_rgba8_straight.sv
`timescale 1ns / 1ps
// Top level: three color lanes side by side, alpha and beat-valid pipeline, merge queue.
// Depends on unpm_pkg, unpm_lane and unpm_merge.
//
//  channel    handshake                        payload
//  premult    premult_valid / premult_ready    red/green/blue_premult, alpha_in (16 b each)
//  straight   straight_valid / straight_ready  red/green/blue_straight, alpha_out (8 b each)
//
// Throughput: one pixel per cycle while the output queue has room; every lane runs a
// nine-stage restoring divider behind one product stage, one quotient bit per stage.
// Path: each input beat passes the product stage, the divider stages and the output queue.
// Reset clears the beat-valid pipeline and the output queue; no clearing pass.
// The whole pipeline holds only while the two-entry output queue is full, so
// premult_ready never depends on straight_ready in the same cycle.
module rgba16_premult_to_rgba8_straight (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            premult_valid,
	output logic            premult_ready,
	input  unpm_pkg::chan_t red_premult,
	input  unpm_pkg::chan_t green_premult,
	input  unpm_pkg::chan_t blue_premult,
	input  unpm_pkg::chan_t alpha_in,
	output logic            straight_valid,
	input  logic            straight_ready,
	output unpm_pkg::byte_t red_straight,
	output unpm_pkg::byte_t green_straight,
	output unpm_pkg::byte_t blue_straight,
	output unpm_pkg::byte_t alpha_out
);
	import unpm_pkg::*;

	logic   advance;
	logic   vld_s  [PIPE_DEPTH];
	byte_t  aout_s [PIPE_DEPTH];
	byte_t  red_l;
	byte_t  green_l;
	byte_t  blue_l;
	pixel_t pix;

	assign premult_ready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PIPE_DEPTH; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (advance) begin
			vld_s[0] <= premult_valid;
			for (int i = 1; i < PIPE_DEPTH; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			aout_s[0] <= alpha_in[CH_W-1 -: OUT_W];
			for (int i = 1; i < PIPE_DEPTH; i++) begin
				aout_s[i] <= aout_s[i-1];
			end
		end
	end

	unpm_lane u_lane_red (
		.clk      (clk),
		.en       (advance),
		.color    (red_premult),
		.alpha    (alpha_in),
		.straight (red_l)
	);

	unpm_lane u_lane_green (
		.clk      (clk),
		.en       (advance),
		.color    (green_premult),
		.alpha    (alpha_in),
		.straight (green_l)
	);

	unpm_lane u_lane_blue (
		.clk      (clk),
		.en       (advance),
		.color    (blue_premult),
		.alpha    (alpha_in),
		.straight (blue_l)
	);

	unpm_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (advance && vld_s[PIPE_DEPTH-1]),
		.red    (red_l),
		.green  (green_l),
		.blue   (blue_l),
		.alpha  (aout_s[PIPE_DEPTH-1]),
		.room   (advance),
		.valid  (straight_valid),
		.ready  (straight_ready),
		.pix    (pix)
	);

	assign red_straight   = pix.red;
	assign green_straight = pix.green;
	assign blue_straight  = pix.blue;
	assign alpha_out      = pix.alpha;

endmodule

### design/unpm_check.sv
`timescale 1ns / 1ps
// Port-level checks for the converter top level, attached by bind.
// Depends on unpm_pkg and rgba16_premult_to_rgba8_straight.
module unpm_check (
	input logic            clk,
	input logic            arst_n,
	input logic            premult_ready,
	input logic            straight_valid,
	input logic            straight_ready,
	input unpm_pkg::byte_t red_straight,
	input unpm_pkg::byte_t green_straight,
	input unpm_pkg::byte_t blue_straight,
	input unpm_pkg::byte_t alpha_out
);
	import unpm_pkg::*;

	// input side only backs up when finished pixels wait at the output
	a_stall_needs_output: assert property (@(posedge clk) disable iff (!arst_n)
		!premult_ready |-> straight_valid)
		else $error("input stalled with no output beat pending");

	// straight_ready high always frees room for the next input beat
	a_drain_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		straight_ready |=> premult_ready)
		else $error("input not ready after an output drain cycle");

	a_out_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		straight_valid && !straight_ready |=> straight_valid)
		else $error("output beat dropped before acceptance");

	a_out_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		straight_valid && !straight_ready |=>
		$stable(red_straight) && $stable(green_straight) &&
		$stable(blue_straight) && $stable(alpha_out))
		else $error("output payload changed while stalled");

endmodule

bind rgba16_premult_to_rgba8_straight unpm_check u_unpm_check (
	.clk            (clk),
	.arst_n         (arst_n),
	.premult_ready  (premult_ready),
	.straight_valid (straight_valid),
	.straight_ready (straight_ready),
	.red_straight   (red_straight),
	.green_straight (green_straight),
	.blue_straight  (blue_straight),
	.alpha_out      (alpha_out)
);
